// ===== rtl/sqk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sqk_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  localparam int OP_W   = 3;
  localparam int IN_ID_W = 8;
  localparam int KEY_W  = 64;
  localparam int ST_W   = 2;
  localparam int OUT_ID_W = 8;
  localparam int OCC_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_SORT  = 3'd0,
    OP_INS_TAIL  = 3'd1,
    OP_DEL_ID    = 3'd2,
    OP_GET_HEAD  = 3'd3,
    OP_PEEK_HEAD = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK     = 2'd0,
    STS_NODATA = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  // Result of one pass through the shared compare unit.
  typedef struct packed {
    logic key_le;
    logic id_eq;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/sqk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqk_ram #(
  parameter int DEPTH = sqk_pkg::DEPTH_DEF,
  parameter int WIDTH = sqk_pkg::ID_BITS_DEF + sqk_pkg::KEY_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sqk_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqk_cmp #(
  parameter int ID_BITS = sqk_pkg::ID_BITS_DEF
) (
  input  wire logic [ID_BITS-1:0]       entry_id,
  input  wire logic [sqk_pkg::KEY_W-1:0] entry_key,
  input  wire logic [ID_BITS-1:0]       ref_id,
  input  wire logic [sqk_pkg::KEY_W-1:0] ref_key,
  output sqk_pkg::cmp_res_t             res
);

  // Unsigned key order and id match for the entry under the walk.
  always_comb begin
    res.key_le = (entry_key <= ref_key);
    res.id_eq  = (entry_id == ref_id);
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sorted insert, delete and get walk the stored entries, one entry read per cycle through the single
// memory read port; tail insert skips the reads, and peek, clear, full, empty get and unknown
// operations go straight to the finish step, which waits while an earlier result is untaken.
// Throughput: one item at a time; in_ready returns as the result register loads.
// Reset (synchronous, active low) empties the queue at once; entry storage is not cleared.
module sorted_key_queue #(
  parameter int DEPTH   = sqk_pkg::DEPTH_DEF,
  parameter int ID_BITS = sqk_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sqk_pkg::OP_W-1:0]      in_operation,
  input  wire logic [sqk_pkg::IN_ID_W-1:0]   in_item_id,
  input  wire logic [sqk_pkg::KEY_W-1:0]     in_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sqk_pkg::ST_W-1:0]           out_status,
  output logic [sqk_pkg::OUT_ID_W-1:0]       out_id,
  output logic [sqk_pkg::KEY_W-1:0]          out_key,
  output logic [sqk_pkg::OCC_W-1:0]          out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = sqk_pkg::KEY_W;
  localparam int EW = ID_BITS + KW;

  // Sequencer state
  sqk_pkg::state_t  state_r, state_nxt;
  sqk_pkg::op_t     op_r, op_nxt;
  sqk_pkg::status_t status_r, status_nxt;

  // Latched item
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [KW-1:0]      key_r, key_nxt;

  // Walk control: ridx is the next read address, pidx the address of the data now arriving
  logic [CW-1:0] ridx_r, ridx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          pvld_r, pvld_nxt;
  logic          found_r, found_nxt;
  logic [EW-1:0] carry_r, carry_nxt;
  logic [EW-1:0] pop_r, pop_nxt;

  // Queue state; head mirrors entry 0 so the result never needs an extra read
  logic [CW-1:0] count_r, count_nxt;
  logic [EW-1:0] head_r, head_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  sqk_pkg::status_t             out_status_r, out_status_nxt;
  logic [sqk_pkg::OUT_ID_W-1:0] out_id_r, out_id_nxt;
  logic [KW-1:0]                out_key_r, out_key_nxt;
  logic [sqk_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;

  // Memory and compare unit hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_ren;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  sqk_pkg::cmp_res_t cmp_res;

  logic          full;
  logic          match;
  logic [EW-1:0] res_entry;
  logic [ID_BITS-1:0] in_id_cut;

  sqk_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd_en (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // One compare unit, reused for every entry the walk reads back
  sqk_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .entry_id  (mem_rdata[KW +: ID_BITS]),
    .entry_key (mem_rdata[KW-1:0]),
    .ref_id    (id_r),
    .ref_key   (key_r),
    .res       (cmp_res)
  );

  assign in_id_cut = ID_BITS'(in_item_id);
  assign full      = (count_r == CW'(DEPTH));
  assign in_ready  = (state_r == sqk_pkg::ST_IDLE);

  // Get removes at the head; delete removes at the first id match from the head.
  assign match = (op_r == sqk_pkg::OP_GET_HEAD) ? (pidx_r == '0) : cmp_res.id_eq;

  // The popped entry for a successful get, otherwise the head after the operation
  always_comb begin
    if (op_r == sqk_pkg::OP_GET_HEAD && status_r == sqk_pkg::STS_OK) begin
      res_entry = pop_r;
    end else if (count_r != '0) begin
      res_entry = head_r;
    end else begin
      res_entry = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    ridx_nxt       = ridx_r;
    pidx_nxt       = pidx_r;
    pvld_nxt       = pvld_r;
    found_nxt      = found_r;
    carry_nxt      = carry_r;
    pop_nxt        = pop_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_key_nxt    = out_key_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_ren        = 1'b0;
    mem_raddr      = ridx_r[AW-1:0];

    // Drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sqk_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = sqk_pkg::op_t'(in_operation);
          id_nxt     = in_id_cut;
          key_nxt    = in_key;
          carry_nxt  = {in_id_cut, in_key};
          found_nxt  = 1'b0;
          pvld_nxt   = 1'b0;
          ridx_nxt   = '0;
          status_nxt = sqk_pkg::STS_OK;
          case (sqk_pkg::op_t'(in_operation))
            sqk_pkg::OP_INS_SORT: begin
              if (full) begin
                status_nxt = sqk_pkg::STS_FULL;
                state_nxt  = sqk_pkg::ST_FIN;
              end else begin
                state_nxt = sqk_pkg::ST_WALK;
              end
            end
            sqk_pkg::OP_INS_TAIL: begin
              // Start the walk at the end: no reads, only the final write
              ridx_nxt = count_r;
              if (full) begin
                status_nxt = sqk_pkg::STS_FULL;
                state_nxt  = sqk_pkg::ST_FIN;
              end else begin
                state_nxt = sqk_pkg::ST_WALK;
              end
            end
            sqk_pkg::OP_DEL_ID: begin
              state_nxt = sqk_pkg::ST_WALK;
            end
            sqk_pkg::OP_GET_HEAD: begin
              if (count_r == '0) begin
                status_nxt = sqk_pkg::STS_NODATA;
                state_nxt  = sqk_pkg::ST_FIN;
              end else begin
                state_nxt = sqk_pkg::ST_WALK;
              end
            end
            sqk_pkg::OP_PEEK_HEAD: begin
              if (count_r == '0) begin
                status_nxt = sqk_pkg::STS_NODATA;
              end
              state_nxt = sqk_pkg::ST_FIN;
            end
            sqk_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = sqk_pkg::ST_FIN;
            end
            default: begin
              status_nxt = sqk_pkg::STS_NODATA;
              state_nxt  = sqk_pkg::ST_FIN;
            end
          endcase
        end
      end

      sqk_pkg::ST_WALK: begin
        // Issue the next read while the previous one is evaluated
        pvld_nxt = (ridx_r < count_r);
        if (ridx_r < count_r) begin
          mem_ren  = 1'b1;
          ridx_nxt = ridx_r + CW'(1);
          pidx_nxt = ridx_r[AW-1:0];
        end

        if (pvld_r) begin
          if (op_r == sqk_pkg::OP_INS_SORT) begin
            // From the first larger key on, write the carried entry and carry the one read
            if (found_r || !cmp_res.key_le) begin
              mem_we    = 1'b1;
              mem_waddr = pidx_r;
              mem_wdata = carry_r;
              carry_nxt = mem_rdata;
              found_nxt = 1'b1;
            end
          end else begin
            // After the removed entry, move every entry up by one
            if (found_r) begin
              mem_we    = 1'b1;
              mem_waddr = pidx_r - AW'(1);
              mem_wdata = mem_rdata;
            end else if (match) begin
              found_nxt = 1'b1;
              pop_nxt   = mem_rdata;
            end
          end
        end else if (ridx_r == count_r) begin
          // Walk done: finish the operation
          if (op_r == sqk_pkg::OP_INS_SORT || op_r == sqk_pkg::OP_INS_TAIL) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            mem_wdata = carry_r;
            count_nxt = count_r + CW'(1);
          end else if (found_r) begin
            count_nxt = count_r - CW'(1);
          end else begin
            status_nxt = sqk_pkg::STS_NODATA;
          end
          state_nxt = sqk_pkg::ST_FIN;
        end
      end

      sqk_pkg::ST_FIN: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_id_nxt     = sqk_pkg::OUT_ID_W'(res_entry[KW +: ID_BITS]);
          out_key_nxt    = res_entry[KW-1:0];
          out_occ_nxt    = sqk_pkg::OCC_W'(count_r);
          state_nxt      = sqk_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sqk_pkg::ST_IDLE;
      end
    endcase

    // Any write to entry 0 is the new head
    if (mem_we && mem_waddr == '0) begin
      head_nxt = mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqk_pkg::ST_IDLE;
      count_r     <= '0;
      pvld_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pvld_r      <= pvld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    ridx_r       <= ridx_nxt;
    pidx_r       <= pidx_nxt;
    carry_r      <= carry_nxt;
    pop_r        <= pop_nxt;
    head_r       <= head_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_key_r    <= out_key_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_key       = out_key_r;
  assign out_occupancy = out_occ_r;

  // The queue never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // A result appears only out of the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sqk_pkg::ST_FIN))
    else $error("result loaded outside finish step");

  // A full report carries a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == sqk_pkg::STS_FULL) |-> (out_occ_r == sqk_pkg::OCC_W'(DEPTH)))
    else $error("full status with queue not full");

  // Storage is written only during a walk
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sqk_pkg::ST_WALK) |-> !mem_we)
    else $error("memory write outside walk");

endmodule

`default_nettype wire

// ===== tb/sv/sorted_key_queue_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the sorted key queue, keeps a shadow copy of the
// queue and compares every result item with the one the shadow predicts.
module sorted_key_queue_checker
  import sqk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [IN_ID_W-1:0]  in_item_id,
  input  logic [KEY_W-1:0]    in_key,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ST_W-1:0]     out_status,
  input  logic [OUT_ID_W-1:0] out_id,
  input  logic [KEY_W-1:0]    out_key,
  input  logic [OCC_W-1:0]    out_occupancy,
  output int                  fail_count,
  output int                  pending_count,
  output int                  results_checked,
  output int                  full_refusals,
  output int                  no_data_hits
);

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [OUT_ID_W-1:0] id;
    logic [KEY_W-1:0]    key;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  logic [IN_ID_W-1:0] held_ids [DEPTH];
  logic [KEY_W-1:0]   held_keys[DEPTH];
  int                 fill_level;
  queue_result_t      awaited_results[$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
    full_refusals   = 0;
    no_data_hits    = 0;
    fill_level      = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] result mismatch: %s", $realtime, what);
  endtask

  // Shift entries from pos upward and drop the new entry into the gap.
  task automatic open_slot(input int pos, input logic [IN_ID_W-1:0] id,
                           input logic [KEY_W-1:0] key);
    for (int i = fill_level; i > pos; i--) begin
      held_ids[i]  = held_ids[i-1];
      held_keys[i] = held_keys[i-1];
    end
    held_ids[pos]  = id;
    held_keys[pos] = key;
    fill_level++;
  endtask

  // Close the gap left by removing the entry at pos.
  task automatic close_slot(input int pos);
    for (int i = pos; i + 1 < fill_level; i++) begin
      held_ids[i]  = held_ids[i+1];
      held_keys[i] = held_keys[i+1];
    end
    fill_level--;
  endtask

  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [IN_ID_W-1:0] id,
                                input logic [KEY_W-1:0] key, output queue_result_t res);
    int   pos;
    logic popped;
    res    = '0;
    popped = 1'b0;
    res.status = STS_OK;
    case (op)
      OP_INS_SORT: begin
        if (fill_level >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          pos = 0;
          while (pos < fill_level && held_keys[pos] <= key) pos++;
          open_slot(pos, id, key);
        end
      end
      OP_INS_TAIL: begin
        if (fill_level >= DEPTH) res.status = STS_FULL;
        else open_slot(fill_level, id, key);
      end
      OP_DEL_ID: begin
        pos = 0;
        while (pos < fill_level && held_ids[pos] != id) pos++;
        if (pos < fill_level) close_slot(pos);
        else res.status = STS_NODATA;
      end
      OP_GET_HEAD: begin
        if (fill_level == 0) begin
          res.status = STS_NODATA;
        end else begin
          res.id  = held_ids[0];
          res.key = held_keys[0];
          popped  = 1'b1;
          close_slot(0);
        end
      end
      OP_PEEK_HEAD: begin
        if (fill_level == 0) res.status = STS_NODATA;
      end
      OP_CLEAR: fill_level = 0;
      default: res.status = STS_NODATA;
    endcase
    if (!popped && fill_level > 0) begin
      res.id  = held_ids[0];
      res.key = held_keys[0];
    end
    res.occupancy = OCC_W'(fill_level);
    if (res.status == STS_FULL) full_refusals++;
    if (res.status == STS_NODATA) no_data_hits++;
  endtask

  always @(posedge clk) begin
    queue_result_t exp_res;
    queue_result_t new_res;
    if (!rst_n) begin
      fill_level = 0;
      awaited_results.delete();
    end else begin
      // A result always belongs to an item accepted at an earlier edge.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result item arrived with nothing outstanding");
        end else begin
          exp_res = awaited_results.pop_front();
          results_checked++;
          if (out_status !== exp_res.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_res.status));
          end
          if (out_id !== exp_res.id) begin
            report_mismatch($sformatf("id %0d, expected %0d", out_id, exp_res.id));
          end
          if (out_key !== exp_res.key) begin
            report_mismatch($sformatf("key %h, expected %h", out_key, exp_res.key));
          end
          if (out_occupancy !== exp_res.occupancy) begin
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      out_occupancy, exp_res.occupancy));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_op(in_operation, in_item_id, in_key, new_res);
        awaited_results.push_back(new_res);
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

// ===== tb/sv/sorted_key_queue_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted key queue. The checker beside the block
// does all prediction and comparison; this module only feeds items, throttles
// the result side and decides pass or fail at the end.
module sorted_key_queue_test;
  import sqk_pkg::*;

  // Operation codes the block does not define; they must report no data with the head.
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_PERIOD = 300;

  // Traffic mixes for the random part.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_BLEND = 2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [IN_ID_W-1:0]  in_item_id = '0;
  logic [KEY_W-1:0]    in_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ST_W-1:0]     out_status;
  logic [OUT_ID_W-1:0] out_id;
  logic [KEY_W-1:0]    out_key;
  logic [OCC_W-1:0]    out_occupancy;

  int fail_count;
  int pending_count;
  int results_checked;
  int full_refusals;
  int no_data_hits;
  int items_sent = 0;

  // Cleared during a stretch of the random part so both sides run flat out.
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  sorted_key_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_item_id    (in_item_id),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_key       (out_key),
    .out_occupancy (out_occupancy)
  );

  sorted_key_queue_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_item_id      (in_item_id),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_key         (out_key),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .full_refusals   (full_refusals),
    .no_data_hits    (no_data_hits)
  );

  // Result side: stall about 30 percent of the time, never during the calm stretch.
  always @(negedge clk) begin
    if (!rst_n) out_ready = 1'b0;
    else out_ready = idle_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  // Offer one item. Idle cycles come first (valid low), then valid rises with
  // the payload and holds until the edge that accepts it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_ID_W-1:0] id,
                           input logic [KEY_W-1:0] key);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_item_id   = id;
    in_key       = key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the input side off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Pick an operation for the given traffic mix; the fill mix drives the queue
  // to full, the drain mix pulls it back to empty.
  function automatic logic [OP_W-1:0] pick_op(input int mix);
    int r;
    int t_sort, t_tail, t_del, t_get, t_peek, t_clear;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        t_sort = 45; t_tail = 70; t_del = 78; t_get = 86; t_peek = 96; t_clear = 97;
      end
      MIX_DRAIN: begin
        t_sort = 15; t_tail = 23; t_del = 53; t_get = 85; t_peek = 95; t_clear = 96;
      end
      default: begin
        t_sort = 30; t_tail = 45; t_del = 65; t_get = 83; t_peek = 95; t_clear = 97;
      end
    endcase
    if (r < t_sort) return OP_INS_SORT;
    if (r < t_tail) return OP_INS_TAIL;
    if (r < t_del) return OP_DEL_ID;
    if (r < t_get) return OP_GET_HEAD;
    if (r < t_peek) return OP_PEEK_HEAD;
    if (r < t_clear) return OP_CLEAR;
    return $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  // Mostly a small id pool so deletes find their target and duplicates occur.
  function automatic logic [IN_ID_W-1:0] pick_id();
    if ($urandom_range(99) < 75) return IN_ID_W'($urandom_range(7));
    return IN_ID_W'($urandom_range(255));
  endfunction

  // Small keys give plenty of ties; the rest spread over the full 64 bits.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 30) return KEY_W'($urandom_range(15));
    if (r < 35) return '0;
    if (r < 40) return KEY_MAX;
    return {$urandom, $urandom};
  endfunction

  initial begin
    int mix;
    mix = MIX_FILL;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reads on an empty queue, undefined codes, ties, duplicate ids.
    send_item(OP_PEEK_HEAD, 8'd0, '0);
    send_item(OP_GET_HEAD, 8'd0, '0);
    send_item(OP_DEL_ID, 8'd0, '0);
    send_item(OP_UNUSED_6, 8'd255, KEY_MAX);
    send_item(OP_UNUSED_7, 8'd0, '0);
    send_item(OP_CLEAR, 8'd0, '0);
    send_item(OP_INS_SORT, 8'd255, KEY_MAX);
    send_item(OP_INS_SORT, 8'd0, '0);
    send_item(OP_INS_SORT, 8'd1, '0);
    send_item(OP_INS_TAIL, 8'd0, 64'd5);
    send_item(OP_INS_SORT, 8'd2, KEY_MAX);
    send_item(OP_PEEK_HEAD, 8'd0, '0);
    send_item(OP_DEL_ID, 8'd0, '0);
    send_item(OP_DEL_ID, 8'd77, '0);
    send_item(OP_UNUSED_6, 8'd0, '0);
    send_item(OP_GET_HEAD, 8'd0, '0);
    send_item(OP_GET_HEAD, 8'd0, '0);
    send_item(OP_CLEAR, 8'd0, '0);
    send_item(OP_GET_HEAD, 8'd0, '0);

    wait_drained();

    // Random: switch traffic mix every 50 items, drain now and then, and run
    // one long calm stretch with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mix = $urandom_range(2);
      if (n > 0 && n % DRAIN_PERIOD == 0) wait_drained();
      idle_on = !(n >= 700 && n < 1100);
      send_item(pick_op(mix), pick_id(), pick_key());
    end
    idle_on = 1'b1;

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(posedge clk);
    // Leave room for a late, unexpected result to show up.
    repeat (24) @(posedge clk);

    $display("Ran %0d operations (directed then random fill, drain and mixed traffic);",
             items_sent);
    $display("checked %0d results, %0d inserts refused when full, %0d no-data outcomes.",
             results_checked, full_refusals, no_data_hits);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
